// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MDD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that an antecedent leads to a consequent in the following cycle.
`define MDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mdd_pkg.sv
// Package of the Morse delay decoder: types, codes and the symbol table.
`default_nettype none

package mdd_pkg;

    // Configuration register width and its widened compare form
    localparam int CFG_BITS     = 16;
    localparam int CFG_EXT_BITS = 32;

    // Symbol collection limits
    localparam int          MAX_ELEMENTS = 6;
    localparam int          COUNT_BITS   = 3;
    localparam logic [2:0]  TOO_LONG     = 3'd7;

    // Character codes
    localparam logic [6:0] UNKNOWN_CHAR = 7'h23;
    localparam logic [6:0] SPACE_CHAR   = 7'h20;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_SHORT = 2'd0,
        REG_LONG  = 2'd1,
        REG_GAP   = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [CFG_BITS-1:0] short_delay;
        logic [CFG_BITS-1:0] long_delay;
        logic [CFG_BITS-1:0] gap_delay;
    } t_cfg;

    // One decoded symbol handed to the output stage
    typedef struct packed {
        logic       valid;
        logic [6:0] ch;
        logic       gap;
    } t_result;

    // Map element count and pattern (dot 0, dash 1, first element high) to ASCII
    function automatic logic [6:0] lookup_symbol(input logic [2:0] len,
                                                 input logic [5:0] bits);
        logic [6:0] ch;
        case ({len, bits})
            {3'd2, 6'd1}:  ch = 7'h41; // A
            {3'd4, 6'd8}:  ch = 7'h42; // B
            {3'd4, 6'd10}: ch = 7'h43; // C
            {3'd3, 6'd4}:  ch = 7'h44; // D
            {3'd1, 6'd0}:  ch = 7'h45; // E
            {3'd4, 6'd2}:  ch = 7'h46; // F
            {3'd3, 6'd6}:  ch = 7'h47; // G
            {3'd4, 6'd0}:  ch = 7'h48; // H
            {3'd2, 6'd0}:  ch = 7'h49; // I
            {3'd4, 6'd7}:  ch = 7'h4A; // J
            {3'd3, 6'd5}:  ch = 7'h4B; // K
            {3'd4, 6'd4}:  ch = 7'h4C; // L
            {3'd2, 6'd3}:  ch = 7'h4D; // M
            {3'd2, 6'd2}:  ch = 7'h4E; // N
            {3'd3, 6'd7}:  ch = 7'h4F; // O
            {3'd4, 6'd6}:  ch = 7'h50; // P
            {3'd4, 6'd13}: ch = 7'h51; // Q
            {3'd3, 6'd2}:  ch = 7'h52; // R
            {3'd3, 6'd0}:  ch = 7'h53; // S
            {3'd1, 6'd1}:  ch = 7'h54; // T
            {3'd3, 6'd1}:  ch = 7'h55; // U
            {3'd4, 6'd1}:  ch = 7'h56; // V
            {3'd3, 6'd3}:  ch = 7'h57; // W
            {3'd4, 6'd9}:  ch = 7'h58; // X
            {3'd4, 6'd11}: ch = 7'h59; // Y
            {3'd4, 6'd12}: ch = 7'h5A; // Z
            {3'd5, 6'd31}: ch = 7'h30; // 0
            {3'd5, 6'd15}: ch = 7'h31; // 1
            {3'd5, 6'd7}:  ch = 7'h32; // 2
            {3'd5, 6'd3}:  ch = 7'h33; // 3
            {3'd5, 6'd1}:  ch = 7'h34; // 4
            {3'd5, 6'd0}:  ch = 7'h35; // 5
            {3'd5, 6'd16}: ch = 7'h36; // 6
            {3'd5, 6'd24}: ch = 7'h37; // 7
            {3'd5, 6'd28}: ch = 7'h38; // 8
            {3'd5, 6'd30}: ch = 7'h39; // 9
            {3'd6, 6'd21}: ch = 7'h2E; // period
            {3'd6, 6'd51}: ch = 7'h2C; // comma
            {3'd6, 6'd56}: ch = 7'h3A; // colon
            {3'd6, 6'd42}: ch = 7'h3B; // semicolon
            {3'd6, 6'd12}: ch = 7'h3F; // question mark
            {3'd6, 6'd33}: ch = 7'h2D; // hyphen
            {3'd6, 6'd13}: ch = 7'h5F; // underscore
            {3'd5, 6'd22}: ch = 7'h28; // open paren
            {3'd6, 6'd45}: ch = 7'h29; // close paren
            {3'd6, 6'd30}: ch = 7'h27; // apostrophe
            {3'd5, 6'd10}: ch = 7'h2B; // plus
            {3'd5, 6'd18}: ch = 7'h2F; // slash
            {3'd6, 6'd26}: ch = 7'h40; // at sign
            {3'd6, 6'd6}:  ch = 7'h23; // hash
            default:       ch = UNKNOWN_CHAR;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: rtl/mdd_apb_regs.sv
// APB register block holding the three delay settings.
`default_nettype none

module mdd_apb_regs (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output mdd_pkg::t_cfg            o_cfg
);

    mdd_pkg::t_cfg    r_cfg;
    mdd_pkg::t_cfg    n_cfg;
    mdd_pkg::t_reg_idx reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = mdd_pkg::t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                mdd_pkg::REG_SHORT: n_cfg.short_delay = pwdata[mdd_pkg::CFG_BITS-1:0];
                mdd_pkg::REG_LONG:  n_cfg.long_delay  = pwdata[mdd_pkg::CFG_BITS-1:0];
                mdd_pkg::REG_GAP:   n_cfg.gap_delay   = pwdata[mdd_pkg::CFG_BITS-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.short_delay <= 16'd1;
            r_cfg.long_delay  <= 16'd3;
            r_cfg.gap_delay   <= 16'd7;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            mdd_pkg::REG_SHORT: prdata = 32'(r_cfg.short_delay);
            mdd_pkg::REG_LONG:  prdata = 32'(r_cfg.long_delay);
            mdd_pkg::REG_GAP:   prdata = 32'(r_cfg.gap_delay);
            default:            prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/mdd_symbol_decode.sv
// Element collector and symbol lookup for one registered timing word.
`default_nettype none

module mdd_symbol_decode #(
    parameter int DELAY_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [DELAY_BITS-1:0] i_delay,
    input  wire logic                  i_final,
    input  wire mdd_pkg::t_cfg         i_cfg,
    input  wire logic                  i_advance,
    output mdd_pkg::t_result           o_result
);

    logic [mdd_pkg::MAX_ELEMENTS-1:0] r_bits;
    logic [mdd_pkg::MAX_ELEMENTS-1:0] n_bits;
    logic [mdd_pkg::COUNT_BITS-1:0]   r_count;
    logic [mdd_pkg::COUNT_BITS-1:0]   n_count;

    logic [mdd_pkg::CFG_EXT_BITS-1:0] short_w;
    logic [mdd_pkg::CFG_EXT_BITS-1:0] long_w;
    logic [mdd_pkg::CFG_EXT_BITS-1:0] gap_w;
    logic                             is_dot;
    logic                             is_dash;

    // Compare settings in the low DELAY_BITS bits
    assign short_w = mdd_pkg::CFG_EXT_BITS'(i_cfg.short_delay);
    assign long_w  = mdd_pkg::CFG_EXT_BITS'(i_cfg.long_delay);
    assign gap_w   = mdd_pkg::CFG_EXT_BITS'(i_cfg.gap_delay);
    assign is_dot  = (i_delay == short_w[DELAY_BITS-1:0]);
    assign is_dash = !is_dot && (i_delay == long_w[DELAY_BITS-1:0]);

    // Emit a symbol on any word that is neither dot nor dash
    assign o_result.valid = i_valid && !is_dot && !is_dash;
    assign o_result.ch    = mdd_pkg::lookup_symbol(r_count, r_bits);
    assign o_result.gap   = (i_delay == gap_w[DELAY_BITS-1:0]) && !i_final;

    // Append an element, saturate the count, or clear on a terminator or a final word
    always_comb begin
        n_bits  = r_bits;
        n_count = r_count;
        if (i_advance) begin
            if (is_dot || is_dash) begin
                if (r_count < mdd_pkg::COUNT_BITS'(mdd_pkg::MAX_ELEMENTS)) begin
                    n_bits  = {r_bits[mdd_pkg::MAX_ELEMENTS-2:0], is_dash};
                    n_count = r_count + 1'b1;
                end else begin
                    n_count = mdd_pkg::TOO_LONG;
                end
            end else begin
                n_bits  = '0;
                n_count = '0;
            end
            if (i_final) begin
                n_bits  = '0;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits  <= '0;
            r_count <= '0;
        end else begin
            r_bits  <= n_bits;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mdd_out_stage.sv
// Result register that sends a symbol and, after a word gap, a space.
`default_nettype none

module mdd_out_stage (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mdd_pkg::t_result i_result,
    input  wire logic             i_out_ready,
    output logic                  o_free,
    output logic                  o_out_valid,
    output logic [6:0]            o_char_code,
    output logic                  o_run_end
);

    logic       r_valid;
    logic       n_valid;
    logic       r_gap_pending;
    logic       n_gap_pending;
    logic [6:0] r_char;
    logic [6:0] n_char;
    logic       r_end;
    logic       n_end;

    // Free when empty or when the held word is the last of its run and leaves now
    assign o_free = !r_valid || (i_out_ready && !r_gap_pending);

    always_comb begin
        n_valid       = r_valid;
        n_gap_pending = r_gap_pending;
        n_char        = r_char;
        n_end         = r_end;
        // Advance: follow a gapped symbol with a space, else drain
        if (r_valid && i_out_ready) begin
            if (r_gap_pending) begin
                n_char        = mdd_pkg::SPACE_CHAR;
                n_end         = 1'b1;
                n_gap_pending = 1'b0;
            end else begin
                n_valid = 1'b0;
            end
        end
        // Load a new symbol
        if (i_result.valid && o_free) begin
            n_valid       = 1'b1;
            n_char        = i_result.ch;
            n_end         = !i_result.gap;
            n_gap_pending = i_result.gap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_gap_pending <= 1'b0;
        end else begin
            r_valid       <= n_valid;
            r_gap_pending <= n_gap_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_end  <= n_end;
    end

    assign o_out_valid = r_valid;
    assign o_char_code = r_char;
    assign o_run_end   = r_end;

endmodule

`default_nettype wire

// File: rtl/morse_delay_decoder_unit.sv
// Top level of the Morse delay decoder: input register, decode, result register.
// A terminating word shows its symbol on o_out_valid after the input register and
// then the result register; dot and dash words give no result.
// Throughput: one timing word per cycle while no result waits for the result register;
// a word gap holds the single result register for the symbol, then a space.
// Reset (synchronous, active low) clears the collected elements, the pipeline
// valids, and restores delays 1, 3 and 7.
`default_nettype none

module morse_delay_decoder_unit #(
    parameter int DELAY_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [DELAY_BITS-1:0] i_delay_value,
    input  wire logic                  i_final_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [6:0]                 o_char_code,
    output logic                       o_run_end,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic      [31:0]           prdata,
    output logic                       pready
);

    mdd_pkg::t_cfg    cfg;
    mdd_pkg::t_result result;

    logic                  r_s1_valid;
    logic                  n_s1_valid;
    logic [DELAY_BITS-1:0] r_s1_delay;
    logic                  r_s1_final;
    logic                  in_fire;
    logic                  s1_adv;
    logic                  out_free;

    mdd_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Input word moves on when it makes no result or the result register frees
    assign s1_adv     = r_s1_valid && (!result.valid || out_free);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (in_fire) begin
            n_s1_valid = 1'b1;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_delay <= i_delay_value;
            r_s1_final <= i_final_item;
        end
    end

    mdd_symbol_decode #(
        .DELAY_BITS (DELAY_BITS)
    ) u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_valid),
        .i_delay   (r_s1_delay),
        .i_final   (r_s1_final),
        .i_cfg     (cfg),
        .i_advance (s1_adv),
        .o_result  (result)
    );

    mdd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_result    (result),
        .i_out_ready (i_out_ready),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_char_code (o_char_code),
        .o_run_end   (o_run_end)
    );

endmodule

`default_nettype wire

// File: rtl/mdd_checker.sv
// Port-level checker for the Morse delay decoder, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module mdd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [6:0] o_char_code,
    input wire logic       o_run_end,
    input wire logic       pready
);

    // Hold a stalled result word
    `MDD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid, "result word dropped while stalled")
    `MDD_ASSERT_NEXT(a_char_hold, o_out_valid && !i_out_ready, $stable(o_char_code), "stalled result word changed")

    // A symbol that does not end its run is followed at once by a space
    `MDD_ASSERT_NEXT(a_space_follows, o_out_valid && i_out_ready && !o_run_end, o_out_valid && (o_char_code == mdd_pkg::SPACE_CHAR) && o_run_end, "space missing after word gap")

    // A space word always closes the run
    `MDD_ASSERT(a_space_ends, !(o_out_valid && (o_char_code == mdd_pkg::SPACE_CHAR)) || o_run_end, "space word without run end")

    // The register port never waits
    `MDD_ASSERT(a_pready, pready, "pready dropped")

endmodule

bind morse_delay_decoder_unit mdd_checker u_mdd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_char_code (o_char_code),
    .o_run_end   (o_run_end),
    .pready      (pready)
);

`default_nettype wire
